// ----- design/assert_macros.svh -----
// Assertion helpers; clk and rst_n are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define PSQ_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/psq_pkg.sv -----
`default_nettype none

package psq_pkg;

    localparam int ADDR_W        = 16;
    localparam int SEQ_W         = 8;
    localparam int OUTCOME_W     = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [OUTCOME_W-1:0] OUT_BCAST = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NEW   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
    } entry_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } query_t;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic [SEQ_W-1:0] seq;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- design/psq_cell.sv -----
`default_nettype none

module psq_cell
    import psq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t entry_in,
    input  wire query_t query_in,
    output entry_t      entry_out,
    output query_t      query_out,
    output cell_stat_t  stat
);

    logic              entry_valid_reg, entry_valid_next;
    logic [ADDR_W-1:0] entry_addr_reg, entry_addr_next;
    logic [SEQ_W-1:0]  entry_seq_reg, entry_seq_next;
    logic              query_valid_reg;
    logic [ADDR_W-1:0] query_addr_reg;
    logic              match;
    logic [SEQ_W-1:0]  seq_inc;

    assign match   = query_valid_reg && entry_valid_reg && (query_addr_reg == entry_addr_reg);
    assign seq_inc = entry_seq_reg + SEQ_W'(1);

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        entry_addr_next  = entry_addr_reg;
        entry_seq_next   = entry_seq_reg;
        if (shift)
        begin
            entry_valid_next = entry_in.valid;
            entry_addr_next  = entry_in.addr;
            entry_seq_next   = entry_in.seq;
        end
        else if (match)
        begin
            entry_seq_next = seq_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            query_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            query_valid_reg <= query_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_addr_reg <= entry_addr_next;
        entry_seq_reg  <= entry_seq_next;
        query_addr_reg <= query_in.addr;
    end

    assign entry_out.valid = entry_valid_reg;
    assign entry_out.addr  = entry_addr_reg;
    assign entry_out.seq   = entry_seq_reg;

    // query walks on to the next cell past a valid, non-matching entry
    assign query_out.valid = query_valid_reg && entry_valid_reg && !match;
    assign query_out.addr  = query_addr_reg;

    assign stat.hit  = match;
    assign stat.miss = query_valid_reg && !entry_valid_reg;
    assign stat.seq  = seq_inc;

endmodule

`default_nettype wire

// ----- design/per_receiver_seqno_table_unit.sv -----
// A broadcast word goes from the accept into the result register, then the output register;
//   a unicast word walks the cells, one cell per cycle, until a hit, a miss or the table end.
// No new word is taken during a search or while the result register is full.
// Results go through a two-deep holding pair, so a new word is taken while one result waits.
// Reset (async, active low): table empty, broadcast counter 1, no result pending.
`default_nettype none

`include "assert_macros.svh"

module per_receiver_seqno_table_unit
    import psq_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [ADDR_W-1:0]    s_tdata,   // receiver_addr
    input  wire logic                 s_tuser,   // is_broadcast
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [SEQ_W-1:0]          m_tdata,   // seq_number
    output logic [OUTCOME_W-1:0]      m_tuser    // outcome
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic                 state_reg, state_next;
    logic [SEQ_W-1:0]     bcast_reg, bcast_next;
    logic [ADDR_W-1:0]    ins_addr_reg, ins_addr_next;
    logic                 res_valid_reg, res_valid_next;
    logic [SEQ_W-1:0]     res_seq_reg, res_seq_next;
    logic [OUTCOME_W-1:0] res_kind_reg, res_kind_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SEQ_W-1:0]     out_seq_reg, out_seq_next;
    logic [OUTCOME_W-1:0] out_kind_reg, out_kind_next;

    entry_t               entry_chain [TABLE_DEPTH+1];
    query_t               query_chain [TABLE_DEPTH+1];
    cell_stat_t           stat_vec    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec, miss_vec, valid_vec;
    logic                 hit_any, miss_any, full_any;
    logic [SEQ_W-1:0]     hit_seq;
    logic                 accept, shift, out_load;

    assign s_tready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign entry_chain[0].valid = 1'b1;
    assign entry_chain[0].addr  = ins_addr_reg;
    assign entry_chain[0].seq   = SEQ_W'(1);
    assign query_chain[0].valid = accept && !s_tuser;
    assign query_chain[0].addr  = s_tdata;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            psq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .entry_in  (entry_chain[g]),
                .query_in  (query_chain[g]),
                .entry_out (entry_chain[g+1]),
                .query_out (query_chain[g+1]),
                .stat      (stat_vec[g])
            );
            assign hit_vec[g]   = stat_vec[g].hit;
            assign miss_vec[g]  = stat_vec[g].miss;
            assign valid_vec[g] = entry_chain[g+1].valid;
        end
    endgenerate

    always_comb
    begin
        hit_seq = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_seq = hit_seq | (stat_vec[i].seq & {SEQ_W{stat_vec[i].hit}});
        end
    end

    assign hit_any  = |hit_vec;
    assign miss_any = |miss_vec;
    assign full_any = query_chain[TABLE_DEPTH].valid;
    assign shift    = (state_reg == ST_SEARCH) && miss_any;
    assign out_load = res_valid_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        bcast_next     = bcast_reg;
        ins_addr_next  = ins_addr_reg;
        res_valid_next = res_valid_reg && !out_load;
        res_seq_next   = res_seq_reg;
        res_kind_next  = res_kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        res_valid_next = 1'b1;
                        res_seq_next   = bcast_reg;
                        res_kind_next  = OUT_BCAST;
                        bcast_next     = bcast_reg + SEQ_W'(1);
                    end
                    else
                    begin
                        ins_addr_next = s_tdata;
                        state_next    = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit_any)
                begin
                    res_valid_next = 1'b1;
                    res_seq_next   = hit_seq;
                    res_kind_next  = OUT_HIT;
                    state_next     = ST_IDLE;
                end
                else if (miss_any)
                begin
                    res_valid_next = 1'b1;
                    res_seq_next   = SEQ_W'(1);
                    res_kind_next  = OUT_NEW;
                    state_next     = ST_IDLE;
                end
                else if (full_any)
                begin
                    res_valid_next = 1'b1;
                    res_seq_next   = SEQ_W'(1);
                    res_kind_next  = OUT_FULL;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_seq_next   = out_seq_reg;
        out_kind_next  = out_kind_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_seq_next   = res_seq_reg;
            out_kind_next  = res_kind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bcast_reg     <= SEQ_W'(1);
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bcast_reg     <= bcast_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_addr_reg <= ins_addr_next;
        res_seq_reg  <= res_seq_next;
        res_kind_reg <= res_kind_next;
        out_seq_reg  <= out_seq_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_seq_reg;
    assign m_tuser  = out_kind_reg;

    `PSQ_ASSERT(a_hit_onehot, $onehot0(hit_vec), "more than one entry hit")
    `PSQ_ASSERT(a_one_end, $onehot0({hit_any, miss_any, full_any}), "search ended twice")
    `PSQ_NEVER(a_gap, ((valid_vec >> 1) & ~valid_vec) != '0, "hole in table")
    `PSQ_NEVER(a_shift_full, shift && valid_vec[TABLE_DEPTH-1], "insert into full table")
    `PSQ_NEVER(a_res_busy, (state_reg == ST_SEARCH) && res_valid_reg, "result held during search")

endmodule

`default_nettype wire

// ----- sim/per_receiver_seqno_table_unit_tb.sv -----
`default_nettype none

module per_receiver_seqno_table_unit_tb;
    import psq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int N_RANDOM    = 700;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN       = DEPTH + 10;

    typedef struct {
        logic              bcast;
        logic [ADDR_W-1:0] addr;
        int                gap;
    } packet_t;

    typedef struct {
        logic [SEQ_W-1:0]     seq;
        logic [OUTCOME_W-1:0] outcome;
    } seqno_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ADDR_W-1:0]    s_tdata  = '0;   // receiver_addr
    logic                 s_tuser  = 1'b0; // is_broadcast
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [SEQ_W-1:0]     m_tdata;         // seq_number
    logic [OUTCOME_W-1:0] m_tuser;         // outcome

    packet_t tx_packets[$];
    seqno_t  issued_q[$];
    int      n_queued   = 0;
    int      words_in   = 0;
    int      words_out  = 0;
    int      errors     = 0;
    int      idle_cycles = 0;
    logic    hold_off   = 1'b0;
    int      hold_cnt   = 0;
    logic    hold_done  = 1'b0;

    // predictor state
    logic [SEQ_W-1:0]  bcast_seq = 8'd1;
    int                stored    = 0;
    logic [ADDR_W-1:0] rx_addr [DEPTH];
    logic [SEQ_W-1:0]  rx_seq  [DEPTH];

    per_receiver_seqno_table_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic seqno_t assign_seqno(logic bcast, logic [ADDR_W-1:0] addr);
        seqno_t r;
        int     hit;
        hit = -1;
        if (bcast)
        begin
            r.seq     = bcast_seq;
            r.outcome = OUT_BCAST;
            bcast_seq = bcast_seq + 8'd1;
        end
        else
        begin
            for (int i = 0; i < stored; i++)
                if (hit < 0 && rx_addr[i] == addr)
                    hit = i;
            if (hit >= 0)
            begin
                rx_seq[hit] = rx_seq[hit] + 8'd1;
                r.seq       = rx_seq[hit];
                r.outcome   = OUT_HIT;
            end
            else if (stored >= DEPTH)
            begin
                r.seq     = 8'd1;
                r.outcome = OUT_FULL;
            end
            else
            begin
                for (int i = stored; i > 0; i--)
                begin
                    rx_addr[i] = rx_addr[i-1];
                    rx_seq[i]  = rx_seq[i-1];
                end
                rx_addr[0] = addr;
                rx_seq[0]  = 8'd1;
                stored++;
                r.seq     = 8'd1;
                r.outcome = OUT_NEW;
            end
        end
        return r;
    endfunction

    task automatic queue_packet(logic bcast, logic [ADDR_W-1:0] addr);
        packet_t p;
        p.bcast = bcast;
        p.addr  = addr;
        // every third block of 50 words goes back to back
        p.gap   = ((n_queued / 50) % 3 == 2) ? 0 : $urandom_range(0, 19);
        tx_packets.push_back(p);
        n_queued++;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                issued_q.push_back(assign_seqno(s_tuser, s_tdata));
                words_in <= words_in + 1;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_packets.size() > 0 && tx_packets[0].gap > 0)
                begin
                    tx_packets[0].gap = tx_packets[0].gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (tx_packets.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= tx_packets[0].bcast;
                    s_tdata  <= tx_packets[0].addr;
                    void'(tx_packets.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin : rx
        int     stall_left;
        seqno_t exp_word;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (issued_q.size() == 0)
                begin
                    $display("%0t: unexpected word, seq_number %0d outcome %0d",
                             $time, m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    exp_word = issued_q.pop_front();
                    if (m_tdata !== exp_word.seq)
                    begin
                        $display("%0t: seq_number expected %0d got %0d",
                                 $time, exp_word.seq, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== exp_word.outcome)
                    begin
                        $display("%0t: outcome expected %0d got %0d",
                                 $time, exp_word.outcome, m_tuser);
                        errors++;
                    end
                end
                words_out <= words_out + 1;
                stall_left = ((words_out / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // long receiver hold-off so the result buffer fills and the input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_off <= 1'b0;
        else if (!hold_done && words_in >= HOLD_AT)
        begin
            if (hold_cnt == HOLD_CYCLES)
            begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            else
            begin
                hold_off <= 1'b1;
                hold_cnt <= hold_cnt + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stim
        logic [ADDR_W-1:0] known [DEPTH];
        logic [ADDR_W-1:0] addr;
        int                r;

        // broadcast ignores the address
        queue_packet(1'b1, 16'h0000);
        queue_packet(1'b1, 16'hFFFF);
        // inserts and hits at both ends of the address range
        queue_packet(1'b0, 16'h0000);
        queue_packet(1'b0, 16'hFFFF);
        queue_packet(1'b0, 16'h0000);
        queue_packet(1'b0, 16'hFFFF);
        // one bit away from a stored address must miss
        queue_packet(1'b0, 16'h7FFF);
        queue_packet(1'b0, 16'hFFFE);
        known[0] = 16'h0000;
        known[1] = 16'hFFFF;
        known[2] = 16'h7FFF;
        known[3] = 16'hFFFE;
        for (int i = 0; i < DEPTH - 4; i++)
        begin
            known[i+4] = ADDR_W'(16'h1000 + 16'h0111 * i);
            queue_packet(1'b0, known[i+4]);
        end
        // table full: twice for the same receiver, then hit on the oldest entry
        queue_packet(1'b0, 16'hA5A5);
        queue_packet(1'b0, 16'hA5A5);
        queue_packet(1'b0, 16'h0000);
        queue_packet(1'b1, 16'h5A5A);

        // hot receiver at the deepest entry so its count wraps
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                queue_packet(1'b1, ADDR_W'($urandom));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    addr = known[0];
                else if (r < 95)
                    addr = known[$urandom_range(0, DEPTH - 1)];
                else
                    addr = ADDR_W'($urandom);
                queue_packet(1'b0, addr);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in != n_queued || issued_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/psq_pkg.sv
design/psq_cell.sv
design/per_receiver_seqno_table_unit.sv
sim/per_receiver_seqno_table_unit_tb.sv
